FILE: rtl/spi_adc_conversion_master_macros.svh
// assertion macros for the spi adc conversion master
`ifndef SPI_ADC_CONVERSION_MASTER_MACROS_SVH
`define SPI_ADC_CONVERSION_MASTER_MACROS_SVH

// same-cycle implication, checked at every clock edge outside reset
`define SACM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SACM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sacm_pkg.sv
// shared constants and types for the spi adc conversion master
package sacm_pkg;

   localparam int CODE_W     = 14;
   localparam int CHANNEL_W  = 3;
   localparam int COUNT_W    = 5;
   localparam int WAIT_W     = 8;
   localparam int PHASE_W    = 3;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [COUNT_W-1:0] CMD_BITS        = 5'd5;
   localparam logic [COUNT_W-1:0] SHORT_READ_BITS = 5'(10 + 1);
   localparam logic [COUNT_W-1:0] LONG_READ_BITS  = 5'(13 + 1);

   localparam logic [WAIT_W-1:0] SAMPLE_WAIT_RESET = 8'd8;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ADC_MODEL   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_WAIT = 1'd1;

   typedef struct packed {
      logic              chip_select_n;
      logic              serial_clock;
      logic              mosi_out;
      logic              busy_res;
      logic              done_res;
      logic [CODE_W-1:0] code;
   } rsp_payload_type;

endpackage

FILE: rtl/sacm_if.sv
// handshake channels of the spi adc conversion master

interface sacm_req_if;
   logic                              valid;
   logic                              ready;
   logic                              start_req;
   logic [sacm_pkg::CHANNEL_W-1:0]    channel;
   logic                              miso_in;

   modport source (output valid, output start_req, output channel, output miso_in,
                   input ready);
   modport sink   (input valid, input start_req, input channel, input miso_in,
                   output ready);
endinterface

interface sacm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           chip_select_n;
   logic                           serial_clock;
   logic                           mosi_out;
   logic                           busy_res;
   logic                           done_res;
   logic [sacm_pkg::CODE_W-1:0]    code;

   modport source (output valid, output chip_select_n, output serial_clock,
                   output mosi_out, output busy_res, output done_res, output code,
                   input ready);
   modport sink   (input valid, input chip_select_n, input serial_clock,
                   input mosi_out, input busy_res, input done_res, input code,
                   output ready);
endinterface

interface sacm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sacm_pkg::CSR_ADDR_W-1:0]   index;
   logic [sacm_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/spi_adc_conversion_master.sv
// top level of the spi adc conversion master: tick sequencer and result buffer
//
// channel   dir  transfer carries
// req_chan  in   one half-bit tick: start_req, channel, miso_in
// rsp_chan  out  line levels after the tick, busy, done and raw code
// csr_chan  in   register write: index, data (always ready)
//
// the sequencer step is one level of logic on the state registers and a new tick is
// taken in every cycle while the skid register is empty
// results sit in an output register backed by one skid register, so a tick is still
// taken while a result waits; req ready drops only when both hold results
// reset is synchronous and active high; it idles the sequencer (clock high, chip
// select high) and loads the register defaults
`include "spi_adc_conversion_master_macros.svh"

module spi_adc_conversion_master (
   input  logic       clock,
   input  logic       reset,
   sacm_req_if.sink   req_chan,
   sacm_rsp_if.source rsp_chan,
   sacm_csr_if.sink   csr_chan
);

   // sequencer phases
   localparam logic [sacm_pkg::PHASE_W-1:0] PH_IDLE = 3'd0;
   localparam logic [sacm_pkg::PHASE_W-1:0] PH_CMD  = 3'd1;
   localparam logic [sacm_pkg::PHASE_W-1:0] PH_WAIT = 3'd2;
   localparam logic [sacm_pkg::PHASE_W-1:0] PH_DC   = 3'd3;
   localparam logic [sacm_pkg::PHASE_W-1:0] PH_READ = 3'd4;

   // configuration registers
   logic                              adc_model_ff;
   logic [sacm_pkg::WAIT_W-1:0]       sample_wait_ff;

   // sequencer state
   logic [sacm_pkg::PHASE_W-1:0]      phase_ff, phase_in;
   logic [sacm_pkg::COUNT_W-1:0]      bit_count_ff, bit_count_in;
   logic                              half_bit_ff, half_bit_in;
   logic [sacm_pkg::CODE_W-1:0]       shift_ff, shift_in;
   logic [sacm_pkg::CHANNEL_W-1:0]    channel_ff, channel_in;
   logic [sacm_pkg::WAIT_W-1:0]       wait_count_ff, wait_count_in;
   logic                              clock_level_ff, clock_level_in;
   logic                              dout_level_ff, dout_level_in;

   // result buffer
   sacm_pkg::rsp_payload_type         out_ff, skid_ff, result;
   logic                              out_valid_ff, skid_valid_ff;

   logic                              req_fire, rsp_fire;
   logic                              cmd_bit;
   logic                              done;
   logic [sacm_pkg::CODE_W-1:0]       code;
   logic [sacm_pkg::COUNT_W-1:0]      read_bits;
   logic [sacm_pkg::COUNT_W-1:0]      bit_count_inc;
   logic [sacm_pkg::WAIT_W-1:0]       wait_dec;

   assign req_chan.ready = ~skid_valid_ff;
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign rsp_fire       = out_valid_ff & rsp_chan.ready;

   assign csr_chan.ready = 1'b1;

   // register writes, to be made only while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         adc_model_ff   <= 1'b0;
         sample_wait_ff <= sacm_pkg::SAMPLE_WAIT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            sacm_pkg::CSR_ADC_MODEL:   adc_model_ff   <= csr_chan.data[0];
            sacm_pkg::CSR_SAMPLE_WAIT: sample_wait_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign read_bits     = adc_model_ff ? sacm_pkg::LONG_READ_BITS : sacm_pkg::SHORT_READ_BITS;
   assign bit_count_inc = bit_count_ff + 5'd1;
   assign wait_dec      = wait_count_ff - 8'd1;

   // command word: start, single-ended, then channel msb first
   always_comb begin
      case (bit_count_ff)
         5'd0, 5'd1: cmd_bit = 1'b1;
         5'd2:       cmd_bit = channel_ff[2];
         5'd3:       cmd_bit = channel_ff[1];
         default:    cmd_bit = channel_ff[0];
      endcase
   end

   // one tick of the sequencer
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      half_bit_in    = half_bit_ff;
      shift_in       = shift_ff;
      channel_in     = channel_ff;
      wait_count_in  = wait_count_ff;
      clock_level_in = clock_level_ff;
      dout_level_in  = dout_level_ff;
      done           = 1'b0;
      code           = '0;

      unique case (phase_ff)
         PH_CMD: begin
            if (!half_bit_ff) begin
               clock_level_in = 1'b0;
               dout_level_in  = cmd_bit;
               half_bit_in    = 1'b1;
            end else begin
               clock_level_in = 1'b1;
               half_bit_in    = 1'b0;
               bit_count_in   = bit_count_inc;
               if (bit_count_inc >= sacm_pkg::CMD_BITS) begin
                  bit_count_in = '0;
                  if (sample_wait_ff == '0) begin
                     phase_in = PH_DC;
                  end else begin
                     wait_count_in = sample_wait_ff;
                     phase_in      = PH_WAIT;
                  end
               end
            end
         end
         PH_WAIT: begin
            clock_level_in = 1'b1;
            wait_count_in  = wait_dec;
            if (wait_dec == '0) begin
               phase_in = PH_DC;
            end
         end
         PH_DC: begin
            if (!half_bit_ff) begin
               clock_level_in = 1'b0;
               dout_level_in  = 1'b0;
               half_bit_in    = 1'b1;
            end else begin
               clock_level_in = 1'b1;
               half_bit_in    = 1'b0;
               bit_count_in   = '0;
               phase_in       = PH_READ;
            end
         end
         PH_READ: begin
            if (!half_bit_ff) begin
               // sample data-in in the clock-low half
               clock_level_in = 1'b0;
               shift_in       = {shift_ff[sacm_pkg::CODE_W-2:0], req_chan.miso_in};
               bit_count_in   = bit_count_inc;
               half_bit_in    = 1'b1;
            end else begin
               clock_level_in = 1'b1;
               half_bit_in    = 1'b0;
               if (bit_count_ff >= read_bits) begin
                  done         = 1'b1;
                  code         = shift_ff;
                  bit_count_in = '0;
                  phase_in     = PH_IDLE;
               end
            end
         end
         default: begin
            // idle, also recovers from an unused phase code
            phase_in       = PH_IDLE;
            clock_level_in = 1'b1;
            if (req_chan.start_req) begin
               channel_in   = req_chan.channel;
               shift_in     = '0;
               bit_count_in = '0;
               half_bit_in  = 1'b0;
               phase_in     = PH_CMD;
            end
         end
      endcase
   end

   always_comb begin
      result.chip_select_n = (phase_in == PH_IDLE);
      result.serial_clock  = clock_level_in;
      result.mosi_out      = dout_level_in;
      result.busy_res      = (phase_in != PH_IDLE);
      result.done_res      = done;
      result.code          = code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         half_bit_ff    <= 1'b0;
         shift_ff       <= '0;
         channel_ff     <= '0;
         wait_count_ff  <= '0;
         clock_level_ff <= 1'b1;
         dout_level_ff  <= 1'b0;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         half_bit_ff    <= half_bit_in;
         shift_ff       <= shift_in;
         channel_ff     <= channel_in;
         wait_count_ff  <= wait_count_in;
         clock_level_ff <= clock_level_in;
         dout_level_ff  <= dout_level_in;
      end
   end

   // output register with a skid register behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_ff <= skid_ff;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.chip_select_n = out_ff.chip_select_n;
   assign rsp_chan.serial_clock  = out_ff.serial_clock;
   assign rsp_chan.mosi_out      = out_ff.mosi_out;
   assign rsp_chan.busy_res      = out_ff.busy_res;
   assign rsp_chan.done_res      = out_ff.done_res;
   assign rsp_chan.code          = out_ff.code;

   // skid register only fills behind a held output
   `SACM_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid holds a transfer with empty output register")
   // a full buffer takes no tick and keeps its skid entry until the output moves
   `SACM_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !rsp_chan.ready, skid_valid_ff, "skid entry lost while output stalled")
   // command bit index stays within the command word
   `SACM_ASSERT_IMPLIES(a_cmd_count, clock, reset, phase_ff == PH_CMD, bit_count_ff < sacm_pkg::CMD_BITS, "command bit index out of range")
   // the wait phase always starts and stays on a bit boundary
   `SACM_ASSERT_IMPLIES(a_wait_aligned, clock, reset, phase_ff == PH_WAIT, !half_bit_ff && clock_level_ff, "wait phase off bit boundary")

endmodule

FILE: verif/tb_spi_adc_conversion_master.sv
// self-checking testbench for the spi adc conversion master: scripted and random ticks
`timescale 1ns / 1ps

module tb_spi_adc_conversion_master;

   // no transfer of any kind for this many cycles ends the run as hung
   localparam int QUIET_LIMIT = 2000;
   // receiver hold-off long enough to fill the output register and the skid register
   localparam int HOLD_OFF_CYCLES = 150;

   // line levels that can be read straight off the behaviour
   localparam sacm_pkg::rsp_payload_type IDLE_LEVELS =
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 14'h0000};
   localparam sacm_pkg::rsp_payload_type DONE_ONES =
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 14'h07FF};
   localparam sacm_pkg::rsp_payload_type DONE_ZEROS =
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 14'h0000};
   localparam sacm_pkg::rsp_payload_type NO_LEVELS = '0;

   // sequencer steps of the predictor
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_CMD,
      SEQ_WAIT,
      SEQ_DC,
      SEQ_READ
   } seq_state_type;

   // receiver back-pressure patterns
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_EVERY_THIRD,
      STALL_SPARSE
   } stall_mode_type;

   // one scripted row: a tick repeated reps times, with optional fixed expectation
   typedef struct {
      logic                           start;
      logic [sacm_pkg::CHANNEL_W-1:0] chan;
      logic                           miso;
      int                             reps;
      bit                             fixed;
      sacm_pkg::rsp_payload_type      want;
   } tick_row_type;

   // reset settings: 11-bit read, wait of 8, so a conversion is 42 ticks after the start tick
   tick_row_type script_rows [9] = '{
      // first tick after reset, no start: everything idle
      '{1'b0, 3'd0, 1'b0,  1, 1'b1, IDLE_LEVELS},
      // start on the highest channel
      '{1'b1, 3'd7, 1'b0,  1, 1'b0, NO_LEVELS},
      // start held high while busy, data line stuck high
      '{1'b1, 3'd0, 1'b1, 41, 1'b0, NO_LEVELS},
      // start on the done tick is ignored; code is all ones
      '{1'b1, 3'd0, 1'b1,  1, 1'b1, DONE_ONES},
      '{1'b0, 3'd3, 1'b0,  1, 1'b1, IDLE_LEVELS},
      // mixed channel bits, data line stuck low
      '{1'b1, 3'd5, 1'b0,  1, 1'b0, NO_LEVELS},
      '{1'b0, 3'd2, 1'b0, 41, 1'b0, NO_LEVELS},
      '{1'b0, 3'd0, 1'b0,  1, 1'b1, DONE_ZEROS},
      // data line is ignored while idle
      '{1'b0, 3'd6, 1'b1,  1, 1'b1, IDLE_LEVELS}
   };

   logic clock;
   logic reset;

   sacm_req_if req_if ();
   sacm_rsp_if rsp_if ();
   sacm_csr_if csr_if ();

   spi_adc_conversion_master u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predictor copy of the register settings
   logic                           cfg_model;
   logic [sacm_pkg::WAIT_W-1:0]    cfg_wait;

   // predictor copy of the sequencer
   seq_state_type                  seq_state;
   logic [sacm_pkg::COUNT_W-1:0]   bit_cnt;
   logic                           half_high;
   logic [sacm_pkg::CODE_W-1:0]    shift_q;
   logic [sacm_pkg::CHANNEL_W-1:0] chan_q;
   logic [sacm_pkg::WAIT_W-1:0]    wait_cnt;
   logic                           sclk_q;
   logic                           mosi_q;

   // line levels predicted for every accepted tick, oldest first
   sacm_pkg::rsp_payload_type      line_levels_q [$];

   int fail_count   = 0;
   int ticks_sent   = 0;
   int codes_seen   = 0;
   int settings_set = 0;
   int burst_left   = 0;
   int hold_left    = 0;
   bit calm         = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor reset, matching the block's reset state and register defaults
   function automatic void adc_reset();
      cfg_model = 1'b0;
      cfg_wait  = sacm_pkg::SAMPLE_WAIT_RESET;
      seq_state = SEQ_IDLE;
      bit_cnt   = '0;
      half_high = 1'b0;
      shift_q   = '0;
      chan_q    = '0;
      wait_cnt  = '0;
      sclk_q    = 1'b1;
      mosi_q    = 1'b0;
   endfunction

   // one half-bit tick of the predictor; returns the line levels after the tick
   function automatic sacm_pkg::rsp_payload_type adc_tick(
      input logic start, input logic [sacm_pkg::CHANNEL_W-1:0] chan, input logic miso);
      sacm_pkg::rsp_payload_type    levels;
      logic                         done;
      logic [sacm_pkg::CODE_W-1:0]  code;
      logic [sacm_pkg::COUNT_W-1:0] read_len;
      done     = 1'b0;
      code     = '0;
      read_len = cfg_model ? sacm_pkg::LONG_READ_BITS : sacm_pkg::SHORT_READ_BITS;
      case (seq_state)
         SEQ_CMD: begin
            if (!half_high) begin
               sclk_q    = 1'b0;
               // start and single-ended bits first, then channel msb first
               mosi_q    = (bit_cnt < 5'd2) ? 1'b1 : chan_q[4 - int'(bit_cnt)];
               half_high = 1'b1;
            end else begin
               sclk_q    = 1'b1;
               half_high = 1'b0;
               bit_cnt   = bit_cnt + 5'd1;
               if (bit_cnt >= sacm_pkg::CMD_BITS) begin
                  bit_cnt = '0;
                  if (cfg_wait == '0) begin
                     seq_state = SEQ_DC;
                  end else begin
                     wait_cnt  = cfg_wait;
                     seq_state = SEQ_WAIT;
                  end
               end
            end
         end
         SEQ_WAIT: begin
            sclk_q   = 1'b1;
            wait_cnt = wait_cnt - 8'd1;
            if (wait_cnt == '0) seq_state = SEQ_DC;
         end
         SEQ_DC: begin
            if (!half_high) begin
               sclk_q    = 1'b0;
               mosi_q    = 1'b0;
               half_high = 1'b1;
            end else begin
               sclk_q    = 1'b1;
               half_high = 1'b0;
               bit_cnt   = '0;
               seq_state = SEQ_READ;
            end
         end
         SEQ_READ: begin
            if (!half_high) begin
               sclk_q    = 1'b0;
               shift_q   = {shift_q[sacm_pkg::CODE_W-2:0], miso};
               bit_cnt   = bit_cnt + 5'd1;
               half_high = 1'b1;
            end else begin
               sclk_q    = 1'b1;
               half_high = 1'b0;
               if (bit_cnt >= read_len) begin
                  done      = 1'b1;
                  code      = shift_q;
                  bit_cnt   = '0;
                  seq_state = SEQ_IDLE;
               end
            end
         end
         default: begin
            seq_state = SEQ_IDLE;
            sclk_q    = 1'b1;
            if (start) begin
               chan_q    = chan;
               shift_q   = '0;
               bit_cnt   = '0;
               half_high = 1'b0;
               seq_state = SEQ_CMD;
            end
         end
      endcase
      levels.chip_select_n = (seq_state == SEQ_IDLE);
      levels.serial_clock  = sclk_q;
      levels.mosi_out      = mosi_q;
      levels.busy_res      = (seq_state != SEQ_IDLE);
      levels.done_res      = done;
      levels.code          = code;
      return levels;
   endfunction

   function automatic void check_field(input string name,
                                       input logic [sacm_pkg::CODE_W-1:0] want,
                                       input logic [sacm_pkg::CODE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // offer one tick; the sender runs in bursts with random gaps between them
   task automatic send_tick(input logic start, input logic [sacm_pkg::CHANNEL_W-1:0] chan,
                            input logic miso, input bit fixed,
                            input sacm_pkg::rsp_payload_type fixed_want);
      sacm_pkg::rsp_payload_type want;
      int                        gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.start_req <= start;
      req_if.channel   <= chan;
      req_if.miso_in   <= miso;
      do @(posedge clock); while (!req_if.ready);
      // transfer taken at this edge: step the predictor
      want = adc_tick(start, chan, miso);
      if (fixed) want = fixed_want;
      line_levels_q.push_back(want);
      ticks_sent++;
      @(negedge clock);
   endtask

   // clock out the running conversion, then let every result drain before any register write
   task automatic finish_phase();
      while (seq_state != SEQ_IDLE)
         send_tick(1'b0, sacm_pkg::CHANNEL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'b0, NO_LEVELS);
      req_if.valid <= 1'b0;
      while (line_levels_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // both registers, one transfer each; entered and left at a falling edge
   task automatic apply_settings(input logic model,
                                 input logic [sacm_pkg::WAIT_W-1:0] wait_ticks);
      csr_if.valid <= 1'b1;
      csr_if.index <= sacm_pkg::CSR_ADC_MODEL;
      csr_if.data  <= sacm_pkg::CSR_DATA_W'(model);
      do @(posedge clock); while (!csr_if.ready);
      cfg_model = model;
      @(negedge clock);
      csr_if.index <= sacm_pkg::CSR_SAMPLE_WAIT;
      csr_if.data  <= wait_ticks;
      do @(posedge clock); while (!csr_if.ready);
      cfg_wait = wait_ticks;
      @(negedge clock);
      csr_if.valid <= 1'b0;
      settings_set++;
   endtask

   // random ticks under one setting; starts are likely when idle, occasional stray ones when busy
   task automatic run_phase(input logic model, input logic [sacm_pkg::WAIT_W-1:0] wait_ticks,
                            input int count, input bit no_gaps, input bit squeeze);
      logic start;
      apply_settings(model, wait_ticks);
      calm       = no_gaps;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (squeeze && i == 15) hold_left = HOLD_OFF_CYCLES;
         start = (seq_state == SEQ_IDLE) ? ($urandom_range(0, 3) != 0)
                                         : ($urandom_range(0, 5) == 0);
         send_tick(start, sacm_pkg::CHANNEL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'b0, NO_LEVELS);
      end
      finish_phase();
   endtask

   // receiver: switches between random stall patterns, honours a requested hold-off
   initial begin
      stall_mode_type stall_mode;
      int             mode_left;
      stall_mode     = STALL_NONE;
      mode_left      = 0;
      rsp_if.ready  <= 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 60);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (stall_mode)
               STALL_NONE:        rsp_if.ready <= 1'b1;
               STALL_COIN:        rsp_if.ready <= 1'($urandom_range(0, 1));
               STALL_EVERY_THIRD: rsp_if.ready <= (mode_left % 3 != 0);
               default:           rsp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // result checker: every result transfer is matched against the oldest prediction
   always @(posedge clock) begin
      sacm_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (line_levels_q.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            want = line_levels_q.pop_front();
            check_field("chip_select_n", sacm_pkg::CODE_W'(want.chip_select_n),
                        sacm_pkg::CODE_W'(rsp_if.chip_select_n));
            check_field("serial_clock", sacm_pkg::CODE_W'(want.serial_clock),
                        sacm_pkg::CODE_W'(rsp_if.serial_clock));
            check_field("mosi_out", sacm_pkg::CODE_W'(want.mosi_out),
                        sacm_pkg::CODE_W'(rsp_if.mosi_out));
            check_field("busy_res", sacm_pkg::CODE_W'(want.busy_res),
                        sacm_pkg::CODE_W'(rsp_if.busy_res));
            check_field("done_res", sacm_pkg::CODE_W'(want.done_res),
                        sacm_pkg::CODE_W'(rsp_if.done_res));
            check_field("code", want.code, rsp_if.code);
            if (want.done_res) codes_seen++;
         end
      end
   end

   // watchdog: any transfer on any channel resets the quiet count
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, line_levels_q.size());
      $display("** spi_adc_conversion_master: FAILED **");
      $finish;
   end

   // main sequence
   initial begin
      req_if.valid     <= 1'b0;
      req_if.start_req <= 1'b0;
      req_if.channel   <= '0;
      req_if.miso_in   <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= sacm_pkg::CSR_ADC_MODEL;
      csr_if.data      <= '0;
      reset = 1'b1;
      adc_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // scripted part under the reset settings
      calm = 1'b0;
      foreach (script_rows[r])
         repeat (script_rows[r].reps)
            send_tick(script_rows[r].start, script_rows[r].chan, script_rows[r].miso,
                      script_rows[r].fixed, script_rows[r].want);
      finish_phase();

      // random part: long read with no wait (and the receiver hold-off), longest wait, shortest
      // non-zero wait without sender gaps, short read with no wait, then back to the reset settings
      run_phase(1'b1, 8'd0,   50, 1'b0, 1'b1);
      run_phase(1'b0, 8'd255, 20, 1'b0, 1'b0);
      run_phase(1'b1, 8'd1,   20, 1'b1, 1'b0);
      run_phase(1'b0, 8'd0,   15, 1'b0, 1'b0);
      run_phase(1'b0, sacm_pkg::SAMPLE_WAIT_RESET, 15, 1'b0, 1'b0);

      // every prediction is consumed by now; allow the pipeline to settle
      while (line_levels_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d ticks and %0d finished conversions over %0d register settings,",
               ticks_sent, codes_seen, settings_set);
      $display("both read lengths, zero and maximum wait, stray starts and a full output stall");
      if (fail_count == 0)
         $display("** spi_adc_conversion_master: PASSED **");
      else
         $display("** spi_adc_conversion_master: FAILED **");
      $finish;
   end

endmodule
